[hw/rtl/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes for the bucketed priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_POPPED    = 3'd1;
  localparam logic [2:0] ST_RETRY     = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  localparam int KEY_W  = 8;
  localparam int ID_W   = 24;
  localparam int PART_W = 4;
  localparam int OCC_W  = 13;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_POP_SCAN,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request word
    logic push_rd;    // read free link / bucket info
    logic push_wr;    // commit push
    logic scan_step;  // look at current bucket, advance pointer
    logic pop_rd;     // read head entry
    logic pop_wr;     // commit pop
    logic fin;        // emit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic push_reject;
    logic pop_empty;
    logic scan_hit;
    logic scan_end;
  } stat_t;

endpackage

[hw/rtl/bpq_ram.sv]
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/bpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bpq_ctrl
// Request sequencer: push, pop scan, pop and result strobe.
// ----------------------------------------------------------------------------
module bpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bpq_pkg::stat_t stat,
  output bpq_pkg::cmd_t  cmd
);
  import bpq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PUSH_RD;
      end
      S_PUSH_RD: begin
        // first cycle after capture decides the route
        if (stat.is_pop) begin
          state_next = stat.pop_empty ? S_DONE : S_POP_SCAN;
        end else begin
          state_next = stat.push_reject ? S_DONE : S_PUSH_WR;
        end
      end
      S_PUSH_WR:  state_next = S_DONE;
      S_POP_SCAN: begin
        if (stat.scan_hit) state_next = S_POP_RD;
        else if (stat.scan_end) state_next = S_DONE;
      end
      S_POP_RD:   state_next = S_POP_WR;
      S_POP_WR:   state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:     cmd.load = start;
      S_PUSH_RD:  cmd.push_rd = 1'b1;
      S_PUSH_WR:  cmd.push_wr = 1'b1;
      S_POP_SCAN: cmd.scan_step = 1'b1;
      S_POP_RD:   cmd.pop_rd = 1'b1;
      S_POP_WR:   cmd.pop_wr = 1'b1;
      S_DONE:     cmd.fin = 1'b1;
      default:    cmd = '0;
    endcase
  end
endmodule

[hw/rtl/bpq_dp.sv]
// ----------------------------------------------------------------------------
// bpq_dp
// Datapath: entry store, bucket head/tail tables, pointers and counters.
// ----------------------------------------------------------------------------
module bpq_dp #(
  parameter int BUCKETS  = 256,
  parameter int CAPACITY = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpq_pkg::cmd_t               cmd,
  output bpq_pkg::stat_t              stat,
  input  logic                        req_type,
  input  logic [bpq_pkg::KEY_W-1:0]   prio_key,
  input  logic [bpq_pkg::ID_W-1:0]    item_id,
  input  logic [bpq_pkg::PART_W-1:0]  item_part,
  input  logic                        check_exhaust,
  input  logic                        workers_busy,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [bpq_pkg::KEY_W-1:0]   out_key,
  output logic [bpq_pkg::ID_W-1:0]    out_id,
  output logic [bpq_pkg::PART_W-1:0]  out_part,
  output logic [bpq_pkg::OCC_W-1:0]   occupancy
);
  import bpq_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = BW + 1;
  localparam int DW = PART_W + ID_W;
  localparam int KW = (KEY_W > PW) ? KEY_W : PW;

  // request word
  logic              r_pop;
  logic [KEY_W-1:0]  r_key;
  logic [ID_W-1:0]   r_id;
  logic [PART_W-1:0] r_part;
  logic              r_exh;

  logic [BUCKETS-1:0] nonempty;
  logic [SW-1:0]      free_head;
  logic [CW-1:0]      fresh_count;
  logic [CW-1:0]      entry_count;
  logic [PW-1:0]      lowest;
  logic [PW-1:0]      scan_b;
  logic [SW-1:0]      slot;

  // track whether this request committed, and hold popped data
  logic          dat_flag, pop_ok;
  logic [DW-1:0] pop_dat;

  // memories
  logic          dat_we, lnk_we, hd_we, tl_we;
  logic [SW-1:0] dat_wa, lnk_wa, lnk_wd, lnk_ra, lnk_rd;
  logic [DW-1:0] dat_wd, dat_rd;
  logic [SW-1:0] dat_ra;
  logic [BW-1:0] hd_wa, tl_wa, tb_ra;
  logic [SW-1:0] hd_wd, tl_wd, hd_rd, tl_rd;

  bpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_dat (
    .clk, .we(dat_we), .waddr(dat_wa), .wdata(dat_wd), .raddr(dat_ra), .rdata(dat_rd));
  bpq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  bpq_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_hd (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(tb_ra), .rdata(hd_rd));
  bpq_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_tl (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tb_ra), .rdata(tl_rd));

  logic [KW-1:0] key_x, buck_x;
  logic          key_bad, use_free, cur_ne, scan_over;
  logic [BW-1:0] kidx, sidx;

  always_comb begin
    key_x  = KW'(r_key);
    buck_x = KW'(BUCKETS);
    key_bad = key_x >= buck_x;
    kidx = r_key[BW-1:0];
    sidx = scan_b[BW-1:0];
    use_free = fresh_count > entry_count;
    scan_over = scan_b >= PW'(BUCKETS);
    cur_ne = !scan_over && nonempty[sidx];
  end

  always_comb begin
    stat.is_pop      = r_pop;
    stat.push_reject = key_bad || (entry_count >= CW'(CAPACITY));
    stat.pop_empty   = (entry_count == '0);
    stat.scan_hit    = cur_ne;
    stat.scan_end    = scan_over;
  end

  // read addresses: free link during push, head link during pop;
  // the tail of the served bucket is read again in pop_rd for pop_wr
  always_comb begin
    tb_ra  = (cmd.scan_step || cmd.pop_rd) ? sidx : kidx;
    lnk_ra = cmd.push_rd ? free_head : hd_rd;
    dat_ra = hd_rd;
    if (cmd.push_rd) tb_ra = kidx;
  end

  // writes
  always_comb begin
    dat_we = cmd.push_wr;
    dat_wa = slot;
    dat_wd = {r_part, r_id};
    lnk_we = 1'b0;
    lnk_wa = tl_rd;
    lnk_wd = slot;
    hd_we  = 1'b0;
    hd_wa  = kidx;
    hd_wd  = slot;
    tl_we  = cmd.push_wr;
    tl_wa  = kidx;
    tl_wd  = slot;
    if (cmd.push_wr) begin
      lnk_we = nonempty[kidx];
      hd_we  = !nonempty[kidx];
    end else if (cmd.pop_wr) begin
      lnk_we = 1'b1;
      lnk_wa = slot;
      lnk_wd = free_head;
      hd_we  = (tl_rd != slot);
      hd_wa  = sidx;
      hd_wd  = lnk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_pop  <= req_type;
      r_key  <= prio_key;
      r_id   <= item_id;
      r_part <= item_part;
      r_exh  <= check_exhaust && !workers_busy;
      scan_b <= lowest;
    end
    if (cmd.push_rd) begin
      slot <= use_free ? free_head : fresh_count[SW-1:0];
    end
    if (cmd.scan_step && !cur_ne && !scan_over) begin
      scan_b <= scan_b + PW'(1);
    end
    if (cmd.pop_rd) begin
      slot <= hd_rd;
    end
  end

  // head read lands in the cycle after the scan hit; link read after pop_rd
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty    <= '0;
      free_head   <= '0;
      fresh_count <= '0;
      entry_count <= '0;
      lowest      <= PW'(BUCKETS);
      done        <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.push_wr) begin
        if (use_free) free_head <= lnk_rd;
        else fresh_count <= fresh_count + CW'(1);
        nonempty[kidx] <= 1'b1;
        entry_count <= entry_count + CW'(1);
        if (PW'(kidx) < lowest) lowest <= PW'(kidx);
      end
      if (cmd.pop_wr) begin
        lowest <= scan_b;
        if (tl_rd == slot) nonempty[sidx] <= 1'b0;
        free_head <= slot;
        entry_count <= entry_count - CW'(1);
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      occupancy <= OCC_W'(entry_count);
      out_key <= '0;
      out_id <= '0;
      out_part <= '0;
      if (!r_pop) begin
        status <= key_bad ? ST_RANGE
                : (entry_count >= CW'(CAPACITY) && !dat_flag) ? ST_FULL : ST_PUSHED;
      end else if (pop_ok) begin
        status   <= ST_POPPED;
        out_key  <= KEY_W'(scan_b);
        out_id   <= pop_dat[ID_W-1:0];
        out_part <= pop_dat[DW-1:ID_W];
      end else begin
        status <= r_exh ? ST_EXHAUSTED : ST_RETRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dat_flag <= 1'b0;
      pop_ok   <= 1'b0;
    end
    if (cmd.push_wr) dat_flag <= 1'b1;
    if (cmd.pop_wr) begin
      pop_ok  <= 1'b1;
      pop_dat <= dat_rd;
    end
  end
endmodule

[hw/rtl/bucket_priority_queue.sv]
// ----------------------------------------------------------------------------
// bucket_priority_queue
// Bucketed min-priority queue, FIFO order within each key.
// ----------------------------------------------------------------------------
// Push: S_PUSH_RD, S_PUSH_WR, S_DONE. Pop: S_PUSH_RD, S_POP_SCAN up from the
// lowest pointer to a nonempty bucket, S_POP_RD, S_POP_WR, S_DONE; an empty
// pop or rejected push goes straight to S_DONE. One request at a time; busy
// stays high through the strobe cycle, so the next word is taken in the cycle
// after it. done is high for one cycle with the result; no back-pressure.
// Reset empties the queue at once; no memory clearing pass is needed.
module bucket_priority_queue #(
  parameter int BUCKETS  = 256,
  parameter int CAPACITY = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [bpq_pkg::KEY_W-1:0]   prio_key,
  input  logic [bpq_pkg::ID_W-1:0]    item_id,
  input  logic [bpq_pkg::PART_W-1:0]  item_part,
  input  logic                        check_exhaust,
  input  logic                        workers_busy,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [bpq_pkg::KEY_W-1:0]   out_key,
  output logic [bpq_pkg::ID_W-1:0]    out_id,
  output logic [bpq_pkg::PART_W-1:0]  out_part,
  output logic [bpq_pkg::OCC_W-1:0]   occupancy
);
  import bpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctl_busy;
  logic  ctl_start;

  // the strobe cycle is not an accepting cycle
  assign ctl_start = start && !done;

  bpq_ctrl u_ctrl (
    .clk, .rst, .start(ctl_start), .busy(ctl_busy), .stat, .cmd);

  bpq_dp #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .stat, .req_type, .prio_key, .item_id, .item_part,
    .check_exhaust, .workers_busy, .done, .status, .out_key, .out_id,
    .out_part, .occupancy);

  // hold off the next word until the result strobe has gone out
  assign busy = ctl_busy || done;
endmodule
